// ----- design/hrk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package hrk_pkg;

	localparam int THRESH_W = 24;
	localparam int IN_W     = 32;
	localparam int VALUE_W  = 34;
	localparam int SLOPE_W  = 17;
	localparam int CURV_W   = 32;
	localparam int TT_W     = 2 * THRESH_W;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 24'd65536;
	localparam logic [SLOPE_W-1:0]  SLOPE_MAX    = 17'h1FFFF;
	localparam logic [32:0]         CURV_SAT     = 33'h080000000;
	localparam logic [CURV_W-1:0]   CURV_MOST_NEG = 32'h80000000;

	// Per-unit pipeline control: advance enable and the entry valid bit.
	typedef struct packed {
		logic en;
		logic valid;
	} hrk_ctl_t;

endpackage
`default_nettype wire

// ----- design/hrk_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipelined integer square root, one result bit per stage.
module hrk_sqrt #(
	parameter int QW = 24,
	parameter int SW = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hrk_pkg::hrk_ctl_t  ctl,
	input  wire logic [2*QW-1:0]    rad,
	input  wire logic [SW-1:0]      side_in,
	output logic                    vld_out,
	output logic [QW-1:0]           root_out,
	output logic [SW-1:0]           side_out
);

	localparam int RW = 2 * QW;

	logic [QW-1:0] vld_s;
	logic [RW-1:0] rad_s  [QW];
	logic [QW:0]   rem_s  [QW];
	logic [QW-1:0] root_s [QW];
	logic [SW-1:0] side_s [QW];

	logic [QW-1:0] c_vld;
	logic [RW-1:0] c_rad  [QW];
	logic [QW:0]   c_rem  [QW];
	logic [QW-1:0] c_root [QW];
	logic [SW-1:0] c_side [QW];

	logic [RW-1:0] n_rad  [QW];
	logic [QW:0]   n_rem  [QW];
	logic [QW-1:0] n_root [QW];

	always_comb begin
		logic [QW+2:0] remc;
		logic [QW+2:0] trial;
		logic          ge;
		c_vld[0]  = ctl.valid;
		c_rad[0]  = rad;
		c_rem[0]  = '0;
		c_root[0] = '0;
		c_side[0] = side_in;
		for (int k = 1; k < QW; k++) begin
			c_vld[k]  = vld_s[k-1];
			c_rad[k]  = rad_s[k-1];
			c_rem[k]  = rem_s[k-1];
			c_root[k] = root_s[k-1];
			c_side[k] = side_s[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			remc  = {c_rem[k], c_rad[k][RW-1:RW-2]};
			trial = {1'b0, c_root[k], 2'b01};
			ge    = (remc >= trial);
			n_rem[k]  = ge ? (QW+1)'(remc - trial) : (QW+1)'(remc);
			n_root[k] = {c_root[k][QW-2:0], ge};
			n_rad[k]  = c_rad[k] << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ctl.en) begin
			vld_s <= c_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int k = 0; k < QW; k++) begin
				rad_s[k]  <= n_rad[k];
				rem_s[k]  <= n_rem[k];
				root_s[k] <= n_root[k];
				side_s[k] <= c_side[k];
			end
		end
	end

	assign vld_out  = vld_s[QW-1];
	assign root_out = root_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule
`default_nettype wire

// ----- design/hrk_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
module hrk_div #(
	parameter int NW = 40,
	parameter int DW = 24,
	parameter int SW = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hrk_pkg::hrk_ctl_t  ctl,
	input  wire logic [NW-1:0]      num,
	input  wire logic [DW-1:0]      den,
	input  wire logic [SW-1:0]      side_in,
	output logic                    vld_out,
	output logic [NW-1:0]           quo_out,
	output logic [SW-1:0]           side_out
);

	logic [NW-1:0] vld_s;
	logic [NW-1:0] num_s  [NW];
	logic [DW-1:0] den_s  [NW];
	logic [DW-1:0] rem_s  [NW];
	logic [NW-1:0] quo_s  [NW];
	logic [SW-1:0] side_s [NW];

	logic [NW-1:0] c_vld;
	logic [NW-1:0] c_num  [NW];
	logic [DW-1:0] c_den  [NW];
	logic [DW-1:0] c_rem  [NW];
	logic [NW-1:0] c_quo  [NW];
	logic [SW-1:0] c_side [NW];

	logic [DW-1:0] n_rem [NW];
	logic [NW-1:0] n_quo [NW];

	always_comb begin
		logic [DW:0] remc;
		logic        ge;
		c_vld[0]  = ctl.valid;
		c_num[0]  = num;
		c_den[0]  = den;
		c_rem[0]  = '0;
		c_quo[0]  = '0;
		c_side[0] = side_in;
		for (int k = 1; k < NW; k++) begin
			c_vld[k]  = vld_s[k-1];
			c_num[k]  = num_s[k-1];
			c_den[k]  = den_s[k-1];
			c_rem[k]  = rem_s[k-1];
			c_quo[k]  = quo_s[k-1];
			c_side[k] = side_s[k-1];
		end
		for (int k = 0; k < NW; k++) begin
			remc = {c_rem[k], c_num[k][NW-1]};
			ge   = (remc >= {1'b0, c_den[k]});
			n_rem[k] = ge ? DW'(remc - {1'b0, c_den[k]}) : DW'(remc);
			n_quo[k] = {c_quo[k][NW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ctl.en) begin
			vld_s <= c_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int k = 0; k < NW; k++) begin
				num_s[k]  <= c_num[k] << 1;
				den_s[k]  <= c_den[k];
				rem_s[k]  <= n_rem[k];
				quo_s[k]  <= n_quo[k];
				side_s[k] <= c_side[k];
			end
		end
	end

	assign vld_out  = vld_s[NW-1];
	assign quo_out  = quo_s[NW-1];
	assign side_out = side_s[NW-1];

endmodule
`default_nettype wire

// ----- design/huber_robust_kernel_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Huber robust kernel: for each squared residual e (unsigned Q16.16) gives the
// Huber cost, its slope and its curvature, plus an inlier flag, with delta from
// the huber_threshold register (unsigned Q8.16, reset 1.0). Fully pipelined:
// one item per cycle while the output is not stalled. The pipe runs through
// the digit-per-stage root (QW stages, where QW = (33 + FRAC_BITS) / 2), the
// stage-1 registers, the slope divider (one stage per numerator bit), the
// curvature divider and the output register. A stall on the output freezes the
// whole pipe; nothing is dropped or repeated. Write the threshold only while no
// transfer is in flight; cfg_ready is always high.
module huber_robust_kernel_core #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [hrk_pkg::THRESH_W-1:0]    huber_threshold,
	// input channel
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [hrk_pkg::IN_W-1:0]        squared_error,
	// result channel
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [hrk_pkg::VALUE_W-1:0]          rho_value,
	output logic [hrk_pkg::SLOPE_W-1:0]          rho_slope,
	output logic signed [hrk_pkg::CURV_W-1:0]    rho_curvature,
	output logic                                 is_inlier
);

	localparam int F    = FRAC_BITS;
	localparam int TW   = hrk_pkg::THRESH_W;
	localparam int XW   = hrk_pkg::IN_W;
	localparam int VW   = hrk_pkg::VALUE_W;
	localparam int SLW  = hrk_pkg::SLOPE_W;
	localparam int TTW  = hrk_pkg::TT_W;
	// root width and radicand width
	localparam int QW   = (XW + F + 1) / 2;
	localparam int RW   = 2 * QW;
	// inlier compare width
	localparam int CW   = (RW > TTW) ? RW : TTW;
	// cost arithmetic width: 2*s*t, t*t and the shifted result window
	localparam int PW0  = QW + TW + 1;
	localparam int PW1  = (PW0 > TTW) ? PW0 : TTW;
	localparam int PW   = (PW1 > F + VW) ? PW1 : F + VW;
	// divider widths
	localparam int N1W  = TW + F;
	localparam int N2W  = 2 * F;
	localparam int MW   = (N2W > 33) ? N2W : 33;
	// unity slope, capped to the port width
	localparam longint ONE_L     = longint'(1) << F;
	localparam longint SLOPE_MAX_L = (longint'(1) << SLW) - 1;
	localparam logic [SLW-1:0] SLOPE_ONE =
		SLW'((ONE_L > SLOPE_MAX_L) ? SLOPE_MAX_L : ONE_L);
	// sideband layouts
	localparam int SB1W = XW + 1 + VW;
	localparam int SB2W = XW + 1 + VW + SLW;

	// ---------------------------------------------------------------
	// Threshold register and its square (recomputed every cycle; the
	// root stages give it ample time to settle after a write).
	// ---------------------------------------------------------------
	logic [TW-1:0]  thr_q;
	logic [TTW-1:0] tt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= hrk_pkg::THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= huber_threshold;
		end
	end

	always_ff @(posedge clk) begin
		tt_q <= TTW'(thr_q) * TTW'(thr_q);
	end

	// ---------------------------------------------------------------
	// Global advance: the pipe moves unless a result is held back.
	// ---------------------------------------------------------------
	logic adv;
	logic out_vld_q;

	assign adv      = !out_vld_q || out_ready;
	assign in_ready = adv;

	// ---------------------------------------------------------------
	// Square root of e in the same format: floor(sqrt(x << F))
	// ---------------------------------------------------------------
	logic [RW-1:0] rad;
	logic          sq_vld;
	logic [QW-1:0] sq_root;
	logic [XW-1:0] sq_x;

	assign rad = RW'(squared_error) << F;

	hrk_sqrt #(
		.QW (QW),
		.SW (XW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      ('{en: adv, valid: in_valid}),
		.rad      (rad),
		.side_in  (squared_error),
		.vld_out  (sq_vld),
		.root_out (sq_root),
		.side_out (sq_x)
	);

	// ---------------------------------------------------------------
	// Stage 1: inlier test and s*t product
	// ---------------------------------------------------------------
	logic              vld_s1;
	logic [XW-1:0]     x_s1;
	logic [QW-1:0]     s_s1;
	logic [QW+TW-1:0]  st_s1;
	logic              inl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= sq_x;
			s_s1   <= sq_root;
			st_s1  <= (QW+TW)'(sq_root) * (QW+TW)'(thr_q);
			inl_s1 <= ((CW'(sq_x) << F) <= CW'(tt_q));
		end
	end

	// outlier cost: (2*s*t - t*t) >> F
	logic [PW-1:0] cost_full;
	logic [VW-1:0] cost_out;

	assign cost_full = (PW'(st_s1) << 1) - PW'(tt_q);
	assign cost_out  = cost_full[F+VW-1:F];

	// ---------------------------------------------------------------
	// Slope: (t << F) / s
	// ---------------------------------------------------------------
	logic [N1W-1:0]  num1;
	logic            d1_vld;
	logic [N1W-1:0]  d1_quo;
	logic [SB1W-1:0] d1_side;

	assign num1 = N1W'(thr_q) << F;

	hrk_div #(
		.NW (N1W),
		.DW (QW),
		.SW (SB1W)
	) u_div_slope (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      ('{en: adv, valid: vld_s1}),
		.num      (num1),
		.den      (s_s1),
		.side_in  ({x_s1, inl_s1, cost_out}),
		.vld_out  (d1_vld),
		.quo_out  (d1_quo),
		.side_out (d1_side)
	);

	logic [XW-1:0]  d1_x;
	logic           d1_inl;
	logic [VW-1:0]  d1_cost;
	logic [SLW-1:0] slope_cap;
	logic [N2W-1:0] num2;

	assign {d1_x, d1_inl, d1_cost} = d1_side;
	assign slope_cap = (d1_quo > N1W'(hrk_pkg::SLOPE_MAX)) ? hrk_pkg::SLOPE_MAX
		: SLW'(d1_quo);
	// for an outlier the slope is at most one, so F+1 bits hold it
	assign num2 = N2W'(d1_quo[F:0]) << (F - 1);

	// ---------------------------------------------------------------
	// Curvature magnitude: (slope << (F-1)) / x
	// ---------------------------------------------------------------
	logic            d2_vld;
	logic [N2W-1:0]  d2_quo;
	logic [SB2W-1:0] d2_side;

	hrk_div #(
		.NW (N2W),
		.DW (XW),
		.SW (SB2W)
	) u_div_curv (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      ('{en: adv, valid: d1_vld}),
		.num      (num2),
		.den      (d1_x),
		.side_in  ({d1_x, d1_inl, d1_cost, slope_cap}),
		.vld_out  (d2_vld),
		.quo_out  (d2_quo),
		.side_out (d2_side)
	);

	logic [XW-1:0]  d2_x;
	logic           d2_inl;
	logic [VW-1:0]  d2_cost;
	logic [SLW-1:0] d2_slope;
	logic [MW-1:0]  mag;
	logic [31:0]    curv_neg;

	assign {d2_x, d2_inl, d2_cost, d2_slope} = d2_side;
	assign mag = MW'(d2_quo);
	// saturate at 2^31; negation of 2^31 lands on the most negative code
	assign curv_neg = (mag > MW'(hrk_pkg::CURV_SAT)) ? hrk_pkg::CURV_MOST_NEG
		: 32'(32'd0 - mag[31:0]);

	// ---------------------------------------------------------------
	// Output register: holds the result until its transfer
	// ---------------------------------------------------------------
	logic [VW-1:0]  value_q;
	logic [SLW-1:0] slope_q;
	logic [31:0]    curv_q;
	logic           inl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inl_q <= d2_inl;
			if (d2_inl) begin
				value_q <= VW'(d2_x);
				slope_q <= SLOPE_ONE;
				curv_q  <= '0;
			end else begin
				value_q <= d2_cost;
				slope_q <= d2_slope;
				curv_q  <= curv_neg;
			end
		end
	end

	assign out_valid     = out_vld_q;
	assign rho_value     = value_q;
	assign rho_slope     = slope_q;
	assign rho_curvature = curv_q;
	assign is_inlier     = inl_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_inlier_flat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_inlier |-> rho_curvature == '0 && rho_slope == SLOPE_ONE)
		else $error("inlier result with non-unit slope or curvature");

	a_slope_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rho_slope <= SLOPE_ONE)
		else $error("slope above one");

	a_curv_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rho_curvature[31] || rho_curvature == '0)
		else $error("positive curvature");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(vld_s1))
		else $error("pipeline moved while stalled");

endmodule
`default_nettype wire
